// ===== rtl/pad_id_to_global_coordinates_core_macros.svh =====
// Assertion helpers for the RTL file that carries checks.
// Every check samples on clk and is switched off while arst_n is low.
`ifndef PAD_ID_TO_GLOBAL_COORDINATES_CORE_MACROS_SVH
`define PAD_ID_TO_GLOBAL_COORDINATES_CORE_MACROS_SVH

// Check a same-cycle implication or a constant-delay sequence.
`define PITGC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define PITGC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pitgc_pkg.sv =====
package pitgc_pkg;

	localparam logic [2:0] NumStations = 3'd5;
	localparam logic [3:0] NumSegments = 4'd12;

	localparam logic [1:0] StatusOk    = 2'd0;
	localparam logic [1:0] StatusBad   = 2'd1;
	localparam logic [1:0] StatusRange = 2'd2;

	// Layout of one station/region: units and pads per unit in x and y.
	typedef struct packed {
		logic [3:0] nlux;
		logic [4:0] npx;
		logic [3:0] nluy;
		logic [3:0] npy;
	} lay_t;

	// Quarter and mirrored segment-within-quarter.
	typedef struct packed {
		logic [1:0] quart;
		logic [1:0] sub;
	} seg_t;

	// One decoded result beat.
	typedef struct packed {
		logic [2:0] station;
		logic [1:0] quarter;
		logic [1:0] region;
		logic [6:0] pad_x;
		logic [3:0] pad_y;
		logic [1:0] status;
	} res_t;

	function automatic lay_t mk_lay(input logic [3:0] nlux, input logic [4:0] npx,
			input logic [3:0] nluy, input logic [3:0] npy);
		lay_t l;
		l.nlux = nlux;
		l.npx  = npx;
		l.nluy = nluy;
		l.npy  = npy;
		return l;
	endfunction

	function automatic lay_t lay_lookup(input logic [2:0] sta, input logic [1:0] rgn);
		lay_t l;
		l = '0;
		case (sta)
			3'd0: begin
				case (rgn)
					2'd0: l = mk_lay(4'd1, 5'd24, 4'd1, 4'd8);
					2'd1: l = mk_lay(4'd1, 5'd24, 4'd2, 4'd4);
					2'd2: l = mk_lay(4'd1, 5'd24, 4'd4, 4'd2);
					default: l = mk_lay(4'd2, 5'd12, 4'd8, 4'd1);
				endcase
			end
			3'd1, 3'd2: begin
				case (rgn)
					2'd0: l = mk_lay(4'd8, 5'd6, 4'd1, 4'd8);
					2'd1: l = mk_lay(4'd4, 5'd12, 4'd2, 4'd4);
					default: l = mk_lay(4'd2, 5'd24, 4'd2, 4'd4);
				endcase
			end
			3'd3, 3'd4: begin
				case (rgn)
					2'd0: l = mk_lay(4'd1, 5'd12, 4'd1, 4'd8);
					2'd1: l = mk_lay(4'd4, 5'd3, 4'd2, 4'd4);
					default: l = mk_lay(4'd2, 5'd6, 4'd2, 4'd4);
				endcase
			end
			default: l = '0;
		endcase
		return l;
	endfunction

	// Odd quarters run their segments in the opposite direction.
	function automatic seg_t seg_split(input logic [3:0] seg);
		seg_t s;
		s = '0;
		case (seg)
			4'd0:  s = {2'd0, 2'd0};
			4'd1:  s = {2'd0, 2'd1};
			4'd2:  s = {2'd0, 2'd2};
			4'd3:  s = {2'd1, 2'd2};
			4'd4:  s = {2'd1, 2'd1};
			4'd5:  s = {2'd1, 2'd0};
			4'd6:  s = {2'd2, 2'd0};
			4'd7:  s = {2'd2, 2'd1};
			4'd8:  s = {2'd2, 2'd2};
			4'd9:  s = {2'd3, 2'd2};
			4'd10: s = {2'd3, 2'd1};
			4'd11: s = {2'd3, 2'd0};
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/pitgc_calc.sv =====
module pitgc_calc (
	input  logic [31:0]           pad_word,
	output pitgc_pkg::res_t       res
);

	logic [2:0] sta;
	logic [1:0] rgn;
	logic [3:0] seg;
	logic [2:0] col;
	logic [2:0] row;
	logic [6:0] px;
	logic [4:0] py;

	pitgc_pkg::lay_t lay;
	pitgc_pkg::seg_t sq;

	logic       bad;
	logic       out_of_range;
	logic       mirror_y;
	logic       mirror_x;
	logic [3:0] py_m;
	logic [3:0] row_m;
	logic [4:0] px_m;
	logic [3:0] col_m;
	logic [3:0] ux;
	logic [3:0] uy;
	logic [8:0] prod_x;
	logic [7:0] prod_y;
	logic [8:0] gx;
	logic [7:0] gy;

	assign sta = pad_word[31:29];
	assign rgn = pad_word[28:27];
	assign seg = pad_word[26:23];
	assign col = pad_word[22:20];
	assign row = pad_word[19:17];
	assign px  = pad_word[13:7];
	assign py  = pad_word[6:2];

	assign lay = pitgc_pkg::lay_lookup(sta, rgn);
	assign sq  = pitgc_pkg::seg_split(seg);

	assign bad = (sta >= pitgc_pkg::NumStations) || (seg >= pitgc_pkg::NumSegments);
	assign out_of_range = ({1'b0, col} >= lay.nlux) || ({1'b0, row} >= lay.nluy) ||
		(px >= {2'b00, lay.npx}) || (py >= {1'b0, lay.npy});

	assign mirror_y = (sq.quart == 2'd1) || (sq.quart == 2'd2);
	assign mirror_x = (sq.quart == 2'd2) || (sq.quart == 2'd3);

	// Local indices are in range here, so the low bits carry the whole value.
	assign py_m  = mirror_y ? (lay.npy - 4'd1 - py[3:0]) : py[3:0];
	assign row_m = mirror_y ? (lay.nluy - 4'd1 - {1'b0, row}) : {1'b0, row};
	assign px_m  = mirror_x ? (lay.npx - 5'd1 - px[4:0]) : px[4:0];
	assign col_m = mirror_x ? (lay.nlux - 4'd1 - {1'b0, col}) : {1'b0, col};

	// Offset by one unit span toward the outer segments.
	assign ux = col_m + ((sq.sub != 2'd0) ? lay.nlux : 4'd0);
	assign uy = row_m + ((sq.sub != 2'd2) ? lay.nluy : 4'd0);

	assign prod_x = 9'(ux) * 9'(lay.npx);
	assign prod_y = 8'(uy) * 8'(lay.npy);
	assign gx     = prod_x + 9'(px_m);
	assign gy     = prod_y + 8'(py_m);

	always_comb begin
		res.station = sta;
		res.region  = rgn;
		if (bad) begin
			res.quarter = 2'd0;
			res.pad_x   = 7'd0;
			res.pad_y   = 4'd0;
			res.status  = pitgc_pkg::StatusBad;
		end else if (out_of_range) begin
			res.quarter = sq.quart;
			res.pad_x   = 7'd0;
			res.pad_y   = 4'd0;
			res.status  = pitgc_pkg::StatusRange;
		end else begin
			res.quarter = sq.quart;
			res.pad_x   = gx[6:0];
			res.pad_y   = gy[3:0];
			res.status  = pitgc_pkg::StatusOk;
		end
	end

endmodule

// ===== rtl/pad_id_to_global_coordinates_core.sv =====
// A taken word passes the input-stage and result-stage registers before done shows it.
// Throughput: one pad word per clock; busy never rises, so start may stay high.
// Each result beat is on the ports for exactly one cycle; the receiver cannot stall.
// Reset (arst_n low, asynchronous) drops any beat in flight and holds done low.
`include "pad_id_to_global_coordinates_core_macros.svh"

module pad_id_to_global_coordinates_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] pad_word,
	output logic        done,
	output logic [2:0]  station,
	output logic [1:0]  quarter,
	output logic [1:0]  region,
	output logic [6:0]  pad_x,
	output logic [3:0]  pad_y,
	output logic [1:0]  status
);

	// Input stage: the accepted pad word and its valid flag.
	logic                  valid_s1;
	logic [31:0]           pad_word_s1;

	// Result stage: the decoded beat that sits on the ports.
	logic                  valid_s2;
	pitgc_pkg::res_t       res_s2;
	pitgc_pkg::res_t       res_calc;

	logic                  accept;

	// The pipeline has no back-pressure, so a new beat is always welcome.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Advance the valid flags every cycle; reset drops anything in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// Payload registers carry no reset; the valid flags qualify them.
	always_ff @(posedge clk) begin
		if (accept) begin
			pad_word_s1 <= pad_word;
		end
		if (valid_s1) begin
			res_s2 <= res_calc;
		end
	end

	// Unpack the fields, look up the layout, mirror and scale to global pads.
	pitgc_calc u_calc (
		.pad_word (pad_word_s1),
		.res      (res_calc)
	);

	assign done    = valid_s2;
	assign station = res_s2.station;
	assign quarter = res_s2.quarter;
	assign region  = res_s2.region;
	assign pad_x   = res_s2.pad_x;
	assign pad_y   = res_s2.pad_y;
	assign status  = res_s2.status;

	// Every accepted beat passes through the input and result stages to done.
	`PITGC_ASSERT(a_done_latency, accept |-> ##2 done, "accepted beat did not reach the output")
	// Hold the input-stage beat into the result stage without loss.
	`PITGC_ASSERT_NEXT(a_s1_to_s2, valid_s1, done, "input-stage beat dropped")
	// A bad station or segment reports zero quarter and coordinates.
	`PITGC_ASSERT(a_bad_zero, done && (status == pitgc_pkg::StatusBad) |-> (quarter == 2'd0) && (pad_x == 7'd0) && (pad_y == 4'd0), "bad id with nonzero coordinates")
	// A good pad lands inside the quarter layout.
	`PITGC_ASSERT(a_ok_bound, done && (status == pitgc_pkg::StatusOk) |-> (pad_x <= 7'd95) && (station <= 3'd4), "good pad outside the layout")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned RandomBeats = 1950;
	localparam int unsigned DrainCycles = 4;

	// One directed row: the pad word, and a typed-in result where it is obvious.
	typedef struct packed {
		logic [31:0]     word;
		logic            fixed;
		pitgc_pkg::res_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] pad_word;
	logic        done;
	logic [2:0]  station;
	logic [1:0]  quarter;
	logic [1:0]  region;
	logic [6:0]  pad_x;
	logic [3:0]  pad_y;
	logic [1:0]  status;

	// Side info that travels with the word on the input ports.
	logic            cur_fixed;
	pitgc_pkg::res_t cur_want;

	pitgc_pkg::res_t pending_coords[$];
	stim_row_t       directed_rows[$];
	int unsigned     err_count = 0;
	int unsigned     cycle_count = 0;

	pad_id_to_global_coordinates_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.pad_word (pad_word),
		.done     (done),
		.station  (station),
		.quarter  (quarter),
		.region   (region),
		.pad_x    (pad_x),
		.pad_y    (pad_y),
		.status   (status)
	);

	always #10 clk = ~clk;

	// Layout table: units in x, pads per unit in x, units in y, pads per unit in y.
	function automatic pitgc_pkg::lay_t pad_layout(input logic [2:0] sta,
			input logic [1:0] rgn);
		pitgc_pkg::lay_t l;
		l = '0;
		if (sta == 3'd0) begin
			case (rgn)
				2'd0: l = {4'd1, 5'd24, 4'd1, 4'd8};
				2'd1: l = {4'd1, 5'd24, 4'd2, 4'd4};
				2'd2: l = {4'd1, 5'd24, 4'd4, 4'd2};
				default: l = {4'd2, 5'd12, 4'd8, 4'd1};
			endcase
		end else if (sta <= 3'd2) begin
			case (rgn)
				2'd0: l = {4'd8, 5'd6, 4'd1, 4'd8};
				2'd1: l = {4'd4, 5'd12, 4'd2, 4'd4};
				default: l = {4'd2, 5'd24, 4'd2, 4'd4};
			endcase
		end else begin
			case (rgn)
				2'd0: l = {4'd1, 5'd12, 4'd1, 4'd8};
				2'd1: l = {4'd4, 5'd3, 4'd2, 4'd4};
				default: l = {4'd2, 5'd6, 4'd2, 4'd4};
			endcase
		end
		return l;
	endfunction

	// Decode one pad word into its global coordinates and status.
	function automatic pitgc_pkg::res_t predict_coords(input logic [31:0] w);
		pitgc_pkg::res_t r;
		pitgc_pkg::lay_t l;
		logic [2:0]      sta;
		logic [1:0]      rgn;
		logic [3:0]      seg;
		int unsigned     col, row, px, py, quart, sub, ux, uy, gx, gy;
		sta = w[31:29];
		rgn = w[28:27];
		seg = w[26:23];
		col = 32'(w[22:20]);
		row = 32'(w[19:17]);
		px  = 32'(w[13:7]);
		py  = 32'(w[6:2]);
		r = '0;
		r.station = sta;
		r.region  = rgn;
		r.status  = pitgc_pkg::StatusOk;
		if (sta >= pitgc_pkg::NumStations || seg >= pitgc_pkg::NumSegments) begin
			r.status = pitgc_pkg::StatusBad;
			return r;
		end
		l = pad_layout(sta, rgn);
		quart = 32'(seg) / 3;
		sub = 32'(seg) % 3;
		// Odd quarters run their segments backwards.
		if (quart == 1 || quart == 3)
			sub = 2 - sub;
		r.quarter = 2'(quart);
		if (col >= l.nlux || row >= l.nluy || px >= l.npx || py >= l.npy) begin
			r.status = pitgc_pkg::StatusRange;
			return r;
		end
		if (quart == 1 || quart == 2) begin
			py  = 32'(l.npy) - 1 - py;
			row = 32'(l.nluy) - 1 - row;
		end
		if (quart == 2 || quart == 3) begin
			px  = 32'(l.npx) - 1 - px;
			col = 32'(l.nlux) - 1 - col;
		end
		uy = (sub <= 1) ? row + 32'(l.nluy) : row;
		ux = (sub >= 1) ? col + 32'(l.nlux) : col;
		gx = ux * 32'(l.npx) + px;
		gy = uy * 32'(l.npy) + py;
		r.pad_x = 7'(gx);
		r.pad_y = 4'(gy);
		return r;
	endfunction

	function automatic logic [31:0] pack_pad(input logic [2:0] sta, input logic [1:0] rgn,
			input logic [3:0] seg, input logic [2:0] col, input logic [2:0] row,
			input logic [6:0] px, input logic [4:0] py);
		return {sta, rgn, seg, col, row, 3'b000, px, py, 2'b00};
	endfunction

	function automatic stim_row_t fixed_row(input logic [31:0] w, input pitgc_pkg::res_t want);
		return {w, 1'b1, want};
	endfunction

	function automatic stim_row_t free_row(input logic [31:0] w);
		return {w, 1'b0, pitgc_pkg::res_t'('0)};
	endfunction

	// Append one row to the directed table.
	function automatic void add_row(input stim_row_t row_in);
		directed_rows.insert(directed_rows.size(), row_in);
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	// Present one beat at the falling edge and hold it until the block takes it.
	task automatic send_beat(input logic [31:0] w, input logic fx,
			input pitgc_pkg::res_t want);
		@(negedge clk);
		start     <= 1'b1;
		pad_word  <= w;
		cur_fixed <= fx;
		cur_want  <= want;
		do @(posedge clk); while (busy);
	endtask

	// Drop start for a number of cycles; scramble the word so it is plainly ignored.
	task automatic idle_for(input int unsigned n);
		repeat (n) begin
			@(negedge clk);
			start    <= 1'b0;
			pad_word <= $urandom;
		end
	endtask

	// Hold off the sender until every beat in flight has come back.
	task automatic drain_results();
		idle_for(1);
		while (pending_coords.size() != 0)
			idle_for(1);
	endtask

	// Build a random pad word: mostly well-formed, then range faults, bad ids, noise.
	function automatic logic [31:0] random_pad();
		logic [31:0]     w;
		logic [2:0]      sta;
		logic [1:0]      rgn;
		logic [3:0]      seg;
		pitgc_pkg::lay_t l;
		int unsigned     pick;
		pick = $urandom_range(0, 99);
		w = $urandom;
		sta = 3'($urandom_range(0, 4));
		rgn = 2'($urandom);
		seg = 4'($urandom_range(0, 11));
		l = pad_layout(sta, rgn);
		if (pick < 70) begin
			w[31:29] = sta;
			w[28:27] = rgn;
			w[26:23] = seg;
			w[22:20] = 3'($urandom_range(0, 32'(l.nlux) - 1));
			w[19:17] = 3'($urandom_range(0, 32'(l.nluy) - 1));
			w[13:7]  = 7'($urandom_range(0, 32'(l.npx) - 1));
			w[6:2]   = 5'($urandom_range(0, 32'(l.npy) - 1));
		end else if (pick < 85) begin
			// Valid station and segment, local indices left to chance.
			w[31:29] = sta;
			w[26:23] = seg;
		end else if (pick < 92) begin
			if ($urandom_range(0, 1) == 0)
				w[31:29] = 3'($urandom_range(5, 7));
			else
				w[26:23] = 4'($urandom_range(12, 15));
		end
		return w;
	endfunction

	// Scoreboard: retire a result beat first, then log the beat taken at this edge.
	always @(posedge clk) begin : score_p
		pitgc_pkg::res_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_coords.size() == 0) begin
					$error("result beat with no pad word outstanding");
					err_count++;
				end else begin
					want = pending_coords.pop_front();
					check_field("station", 32'(want.station), 32'(station));
					check_field("quarter", 32'(want.quarter), 32'(quarter));
					check_field("region", 32'(want.region), 32'(region));
					check_field("pad_x", 32'(want.pad_x), 32'(pad_x));
					check_field("pad_y", 32'(want.pad_y), 32'(pad_y));
					check_field("status", 32'(want.status), 32'(status));
				end
			end
			if (start && !busy)
				pending_coords.insert(pending_coords.size(),
					cur_fixed ? cur_want : predict_coords(pad_word));
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : stim_p
		int unsigned sent;
		int unsigned burst;
		int unsigned pause_at;
		arst_n    = 1'b0;
		start     = 1'b0;
		pad_word  = '0;
		cur_fixed = 1'b0;
		cur_want  = '0;

		// Directed rows: bad ids and range faults typed in, the rest predicted.
		add_row(free_row(32'h0000_0000));
		add_row(fixed_row(32'hFFFF_FFFF,
			{3'd7, 2'd0, 2'd3, 7'd0, 4'd0, pitgc_pkg::StatusBad}));
		add_row(fixed_row(pack_pad(3'd5, 2'd0, 4'd0, 3'd0, 3'd0, 7'd0, 5'd0),
			{3'd5, 2'd0, 2'd0, 7'd0, 4'd0, pitgc_pkg::StatusBad}));
		add_row(fixed_row(pack_pad(3'd0, 2'd1, 4'd12, 3'd0, 3'd0, 7'd0, 5'd0),
			{3'd0, 2'd0, 2'd1, 7'd0, 4'd0, pitgc_pkg::StatusBad}));
		add_row(fixed_row(pack_pad(3'd4, 2'd3, 4'd15, 3'd7, 3'd7, 7'd127, 5'd31),
			{3'd4, 2'd0, 2'd3, 7'd0, 4'd0, pitgc_pkg::StatusBad}));
		add_row(fixed_row(pack_pad(3'd0, 2'd0, 4'd4, 3'd1, 3'd0, 7'd0, 5'd0),
			{3'd0, 2'd1, 2'd0, 7'd0, 4'd0, pitgc_pkg::StatusRange}));
		add_row(fixed_row(pack_pad(3'd0, 2'd0, 4'd7, 3'd0, 3'd1, 7'd0, 5'd0),
			{3'd0, 2'd2, 2'd0, 7'd0, 4'd0, pitgc_pkg::StatusRange}));
		add_row(fixed_row(pack_pad(3'd0, 2'd0, 4'd10, 3'd0, 3'd0, 7'd24, 5'd0),
			{3'd0, 2'd3, 2'd0, 7'd0, 4'd0, pitgc_pkg::StatusRange}));
		add_row(fixed_row(pack_pad(3'd0, 2'd0, 4'd0, 3'd0, 3'd0, 7'd0, 5'd8),
			{3'd0, 2'd0, 2'd0, 7'd0, 4'd0, pitgc_pkg::StatusRange}));
		add_row(fixed_row(pack_pad(3'd3, 2'd1, 4'd0, 3'd0, 3'd0, 7'd3, 5'd0),
			{3'd3, 2'd0, 2'd1, 7'd0, 4'd0, pitgc_pkg::StatusRange}));
		add_row(fixed_row(pack_pad(3'd2, 2'd2, 4'd5, 3'd0, 3'd0, 7'd0, 5'd4),
			{3'd2, 2'd1, 2'd2, 7'd0, 4'd0, pitgc_pkg::StatusRange}));
		// Each segment offset in quarter 0, up to the widest global column.
		add_row(free_row(pack_pad(3'd1, 2'd0, 4'd0, 3'd7, 3'd0, 7'd5, 5'd7)));
		add_row(free_row(pack_pad(3'd1, 2'd0, 4'd1, 3'd7, 3'd0, 7'd5, 5'd7)));
		add_row(free_row(pack_pad(3'd1, 2'd0, 4'd2, 3'd7, 3'd0, 7'd5, 5'd7)));
		// Tallest layout across the mirrored quarters.
		add_row(free_row(pack_pad(3'd0, 2'd3, 4'd3, 3'd1, 3'd7, 7'd11, 5'd0)));
		add_row(free_row(pack_pad(3'd0, 2'd3, 4'd8, 3'd0, 3'd0, 7'd0, 5'd0)));
		add_row(free_row(pack_pad(3'd0, 2'd3, 4'd11, 3'd1, 3'd7, 7'd11, 5'd0)));
		add_row(free_row(pack_pad(3'd0, 2'd2, 4'd6, 3'd0, 3'd3, 7'd23, 5'd1)));
		add_row(free_row(pack_pad(3'd3, 2'd1, 4'd9, 3'd3, 3'd1, 7'd2, 5'd3)));
		add_row(free_row(pack_pad(3'd4, 2'd3, 4'd5, 3'd1, 3'd1, 7'd5, 5'd3)));
		add_row(free_row(pack_pad(3'd2, 2'd1, 4'd4, 3'd3, 3'd1, 7'd11, 5'd3)));
		add_row(free_row(pack_pad(3'd4, 2'd0, 4'd11, 3'd0, 3'd0, 7'd11, 5'd7)));
		// Unused bits set: they must not disturb the decode.
		add_row(free_row(
			pack_pad(3'd1, 2'd2, 4'd7, 3'd1, 3'd1, 7'd23, 5'd3) | 32'h0001_C003));

		// Hold reset, then release it on a falling edge.
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table back to back.
		foreach (directed_rows[i])
			send_beat(directed_rows[i].word, directed_rows[i].fixed, directed_rows[i].want);
		drain_results();

		// Random bursts with random gaps; some gaps are zero so bursts run together.
		sent = 0;
		pause_at = $urandom_range(RandomBeats / 4, 3 * RandomBeats / 4);
		while (sent < RandomBeats) begin
			burst = $urandom_range(1, 60);
			repeat (burst) begin
				if (sent < RandomBeats) begin
					send_beat(random_pad(), 1'b0, pitgc_pkg::res_t'('0));
					sent++;
				end
			end
			if (sent >= pause_at && pause_at != 0) begin
				drain_results();
				pause_at = 0;
			end else if ($urandom_range(0, 3) != 0) begin
				idle_for($urandom_range(1, 6));
			end
		end

		// Wait for the last beats, then let the pipeline settle before the summary.
		drain_results();
		repeat (DrainCycles) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
